// ----- design/bcmp_pkg.sv -----
// ---------------------------------------------------------------------------
// bcmp_pkg
// shared types and constants for the binomial coefficient mod prime core
// ---------------------------------------------------------------------------
package bcmp_pkg;

	localparam int unsigned EXP_BITS = 31;
	localparam int unsigned BIT_W    = $clog2(EXP_BITS);
	localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

	typedef enum logic [2:0] {
		OP_FALL,
		OP_FACT,
		OP_PMUL,
		OP_PSQ,
		OP_FIN
	} op_t;

	typedef enum logic [1:0] {
		RES_ONE,
		RES_ZERO,
		RES_MUL
	} res_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_FALL,
		S_FACT,
		S_PINIT,
		S_PBIT,
		S_PMUL,
		S_PSQ,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		op_t      op;
		logic     step_i;
		logic     pow_init;
		logic     step_bit;
		logic     res_set;
		res_src_t res_src;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic mul_busy;
		logic k_zero;
		logic trivial_zero;
		logic last_i;
		logic last_bit;
		logic ebit;
		logic out_busy;
	} sts_t;

endpackage

// ----- design/bcmp_modmul.sv -----
// ---------------------------------------------------------------------------
// bcmp_modmul
// bit-serial interleaved modular multiplier, x * y mod m, y < m
// ---------------------------------------------------------------------------
module bcmp_modmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] x,
	input  logic [30:0] y,
	input  logic [30:0] m,
	output logic        busy,
	output logic        done,
	output logic [30:0] result
);
	logic [31:0] x_q;
	logic [30:0] y_q;
	logic [30:0] acc_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] t;
	logic [32:0] m1;
	logic [32:0] m2;
	logic [32:0] red;

	always_comb begin
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		t  = {1'b0, acc_q, 1'b0} + (x_q[31] ? {2'b00, y_q} : 33'd0);
		if (t >= m2) begin
			red = t - m2;
		end else if (t >= m1) begin
			red = t - m1;
		end else begin
			red = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[30:0], 1'b0};
			acc_q <= red[30:0];
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = acc_q;

endmodule

// ----- design/bcmp_datapath.sv -----
// ---------------------------------------------------------------------------
// bcmp_datapath
// operand registers, modulus register, multiplier and output register
// ---------------------------------------------------------------------------
module bcmp_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  bcmp_pkg::cmd_t   cmd,
	output bcmp_pkg::sts_t   sts,
	input  logic [31:0]      n_value,
	input  logic [15:0]      k_value,
	input  logic             cfg_wr_en,
	input  logic [30:0]      cfg_wr_data,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [30:0]      binomial_mod
);
	import bcmp_pkg::*;

	logic [30:0] modulus_q;
	logic [31:0] n_q;
	logic [15:0] k_q;
	logic [16:0] i_q;
	logic [BIT_W-1:0] bit_q;
	logic [30:0] fall_q;
	logic [30:0] fact_q;
	logic [30:0] acc_q;
	logic [30:0] sq_q;
	logic [30:0] res_q;
	op_t         op_q;
	logic        out_valid_q;
	logic [30:0] out_q;
	logic [30:0] expo;
	logic [31:0] mx;
	logic [30:0] my;
	logic        mbusy;
	logic        mdone;
	logic [30:0] mres;

	assign expo = modulus_q - 31'd2;

	// operand selection for the shared multiplier
	always_comb begin
		case (cmd.op)
			OP_FALL: begin
				mx = n_q - {15'd0, i_q};
				my = fall_q;
			end
			OP_FACT: begin
				// issued in the same cycle as the step, so i_q still holds i
				mx = {15'd0, i_q} + 32'd1;
				my = fact_q;
			end
			OP_PMUL: begin
				mx = {1'b0, sq_q};
				my = acc_q;
			end
			OP_PSQ: begin
				mx = {1'b0, sq_q};
				my = sq_q;
			end
			default: begin
				mx = {1'b0, acc_q};
				my = fall_q;
			end
		endcase
	end

	bcmp_modmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.x      (mx),
		.y      (my),
		.m      (modulus_q),
		.busy   (mbusy),
		.done   (mdone),
		.result (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= MODULUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				modulus_q <= cfg_wr_data;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= n_value;
			k_q    <= k_value;
			i_q    <= '0;
			fall_q <= 31'd1;
			fact_q <= 31'd1;
		end
		if (cmd.mul_start) begin
			op_q <= cmd.op;
		end
		if (cmd.step_i) begin
			i_q <= i_q + 17'd1;
		end
		if (cmd.pow_init) begin
			acc_q <= 31'd1;
			sq_q  <= fact_q;
			bit_q <= '0;
		end
		if (cmd.step_bit) begin
			bit_q <= bit_q + BIT_W'(1);
		end
		if (mdone) begin
			case (op_q)
				OP_FALL: fall_q <= mres;
				OP_FACT: fact_q <= mres;
				OP_PMUL: acc_q  <= mres;
				OP_PSQ:  sq_q   <= mres;
				default: ;
			endcase
		end
		if (cmd.res_set) begin
			case (cmd.res_src)
				RES_ONE:  res_q <= 31'd1;
				RES_ZERO: res_q <= 31'd0;
				default:  res_q <= mres;
			endcase
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	always_comb begin
		sts.mul_done     = mdone;
		sts.mul_busy     = mbusy;
		sts.k_zero       = (k_q == 16'd0);
		sts.trivial_zero = ({16'd0, k_q} > n_q) || (modulus_q <= 31'd1);
		sts.last_i       = (i_q == {1'b0, k_q});
		sts.last_bit     = (bit_q == BIT_W'(EXP_BITS - 1));
		sts.ebit         = expo[bit_q];
		sts.out_busy     = out_valid_q && !out_ready;
	end

	assign out_valid    = out_valid_q;
	assign binomial_mod = out_q;

endmodule

// ----- design/bcmp_ctrl.sv -----
// ---------------------------------------------------------------------------
// bcmp_ctrl
// sequencer for product steps, fermat inversion and result hand-off
// ---------------------------------------------------------------------------
module bcmp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bcmp_pkg::sts_t sts,
	output bcmp_pkg::cmd_t cmd
);
	import bcmp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (sts.k_zero || sts.trivial_zero) begin
					state_d = S_OUT;
				end else begin
					state_d = S_FALL;
				end
			end
			S_FALL: if (sts.mul_done) state_d = S_FACT;
			S_FACT: begin
				if (sts.mul_done) begin
					state_d = sts.last_i ? S_PINIT : S_FALL;
				end
			end
			S_PINIT: state_d = S_PBIT;
			S_PBIT:  state_d = sts.ebit ? S_PMUL : S_PSQ;
			S_PMUL:  if (sts.mul_done) state_d = S_PSQ;
			S_PSQ: begin
				if (sts.mul_done) begin
					state_d = sts.last_bit ? S_FIN : S_PBIT;
				end
			end
			S_FIN: if (sts.mul_done) state_d = S_OUT;
			S_OUT: if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = OP_FALL;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_CHECK: begin
				if (sts.k_zero) begin
					cmd.res_set = 1'b1;
					cmd.res_src = RES_ONE;
				end else if (sts.trivial_zero) begin
					cmd.res_set = 1'b1;
					cmd.res_src = RES_ZERO;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.op        = OP_FALL;
				end
			end
			S_FALL: begin
				if (sts.mul_done) begin
					cmd.step_i    = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.op        = OP_FACT;
				end
			end
			S_FACT: begin
				if (sts.mul_done && !sts.last_i) begin
					cmd.mul_start = 1'b1;
					cmd.op        = OP_FALL;
				end
			end
			S_PINIT: cmd.pow_init = 1'b1;
			S_PBIT: begin
				cmd.mul_start = 1'b1;
				cmd.op        = sts.ebit ? OP_PMUL : OP_PSQ;
			end
			S_PMUL: begin
				if (sts.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.op        = OP_PSQ;
				end
			end
			S_PSQ: begin
				if (sts.mul_done) begin
					if (sts.last_bit) begin
						cmd.mul_start = 1'b1;
						cmd.op        = OP_FIN;
					end else begin
						cmd.step_bit = 1'b1;
					end
				end
			end
			S_FIN: begin
				if (sts.mul_done) begin
					cmd.res_set = 1'b1;
					cmd.res_src = RES_MUL;
				end
			end
			S_OUT: cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy)
		else $error("multiplier started while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> (state_q == S_FALL || state_q == S_FACT || state_q == S_PMUL
			|| state_q == S_PSQ || state_q == S_FIN))
		else $error("multiplier done outside a wait state");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !sts.mul_busy)
		else $error("multiplier busy while idle");

endmodule

// ----- design/binomial_coefficient_mod_prime_core.sv -----
// ---------------------------------------------------------------------------
// binomial_coefficient_mod_prime_core
// C(n,k) mod p by running products and fermat inversion
// ---------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  input     in   in_valid / in_ready     n_value[31:0], k_value[15:0]
//  output    out  out_valid / out_ready   binomial_mod[30:0]
//  config    in   cfg_wr_en               cfg_wr_data[30:0] (modulus)
//
//  each modular multiply runs in the one shared bit-serial unit (32 steps
//  plus done); after the check an item runs a falling and a factorial
//  multiply per i, then per each of the 31 bits of p-2 an issue state, a
//  multiply if the bit is set and a squaring, then the final multiply and
//  hand-off; k zero, k above n or a modulus below two skip to the hand-off
//  reset: idle, no result pending, modulus 1000000007
//  one item at a time; the next transfer is taken while a result still waits
//  in the output register, output stalls hold only the final hand-off
// ---------------------------------------------------------------------------
module binomial_coefficient_mod_prime_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] n_value,
	input  logic [15:0] k_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] binomial_mod,
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data
);
	import bcmp_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	bcmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bcmp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.n_value      (n_value),
		.k_value      (k_value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.binomial_mod (binomial_mod)
	);

endmodule
